// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hppd assertion failed");
`define HPPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hppd assertion failed");
`else
`define HPPD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HPPD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/hppd_pkg.sv
// ----------------------------------------------------------------------------
// hppd_pkg
// Types and constants shared by the HAM / indexed pixel decoder.
// ----------------------------------------------------------------------------
package hppd_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int SHIFT_BASE  = 10;
  localparam int PLANES_MIN  = 3;
  localparam int PLANES_MAX  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_PIXEL     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CTRL_LOAD  = 2'd0,
    CTRL_BLUE  = 2'd1,
    CTRL_RED   = 2'd2,
    CTRL_GREEN = 2'd3
  } ctrl_e;

  typedef enum logic [1:0] {
    REG_HAM_MODE    = 2'd0,
    REG_PLANE_COUNT = 2'd1,
    REG_LINE_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       ham_mode;
    logic [3:0] plane_count;
    logic [9:0] line_width;
  } cfg_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] addr;
    rgb_t       wdata;
    logic       ham;
    ctrl_e      ctrl;
    logic [7:0] mod;
    logic       line_start;
  } op_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [QUEUE_AW:0]   count;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic b_valid;
  } bk_stat_t;

endpackage

// File: sv/hppd_front.sv
// ----------------------------------------------------------------------------
// hppd_front
// Accepts items, tracks the column, and classifies pixels into queue ops.
// ----------------------------------------------------------------------------
module hppd_front (
  input  logic               clk,
  input  logic               rst,
  input  hppd_pkg::cfg_t     cfg,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  logic               command,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         entry_red,
  input  logic [7:0]         entry_green,
  input  logic [7:0]         entry_blue,
  input  logic [7:0]         pixel_bits,
  input  logic               q_full,
  output logic               q_push,
  output hppd_pkg::op_t      q_op
);

  logic [9:0] col;
  logic [9:0] col_next;
  logic [9:0] col_inc;
  logic [3:0] planes;
  logic [3:0] vbits;
  logic [7:0] value;
  logic [7:0] idx_mask;
  logic       is_pixel;

  assign pix_stall = q_full;
  assign q_push    = pix_valid && !q_full;
  assign is_pixel  = (hppd_pkg::cmd_e'(command) == hppd_pkg::CMD_PIXEL);

  always_comb begin
    if (cfg.plane_count < 4'(hppd_pkg::PLANES_MIN)) begin
      planes = 4'(hppd_pkg::PLANES_MIN);
    end else if (cfg.plane_count > 4'(hppd_pkg::PLANES_MAX)) begin
      planes = 4'(hppd_pkg::PLANES_MAX);
    end else begin
      planes = cfg.plane_count;
    end
    vbits    = planes - 4'd2;
    value    = pixel_bits & ~(8'hFF << vbits);
    idx_mask = ~(8'hFF << planes);

    q_op.cmd        = hppd_pkg::cmd_e'(command);
    q_op.wdata      = '{r: entry_red, g: entry_green, b: entry_blue};
    q_op.ham        = cfg.ham_mode;
    q_op.ctrl       = hppd_pkg::ctrl_e'(2'(pixel_bits >> vbits));
    q_op.mod        = 8'(value << (4'(hppd_pkg::SHIFT_BASE) - planes));
    q_op.line_start = (col == 10'd0);
    if (!is_pixel) begin
      q_op.addr = entry_index;
    end else if (cfg.ham_mode) begin
      q_op.addr = value;
    end else begin
      q_op.addr = pixel_bits & idx_mask;
    end
  end

  always_comb begin
    col_inc  = col + 10'd1;
    col_next = (col_inc == cfg.line_width) ? 10'd0 : col_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 10'd0;
    end else if (q_push && is_pixel) begin
      col <= col_next;
    end
  end

endmodule

// File: sv/hppd_queue.sv
// ----------------------------------------------------------------------------
// hppd_queue
// Short op queue between the front and back parts.
// ----------------------------------------------------------------------------
module hppd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hppd_pkg::op_t      push_op,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output hppd_pkg::op_t      head_op,
  output hppd_pkg::q_stat_t  stat
);

  hppd_pkg::op_t                 slots [hppd_pkg::QUEUE_DEPTH];
  logic [hppd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [hppd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [hppd_pkg::QUEUE_AW:0]   count;
  logic                          do_pop;

  assign full       = (count == (hppd_pkg::QUEUE_AW+1)'(hppd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  assign stat.push  = push;
  assign stat.pop   = do_pop;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/hppd_back.sv
// ----------------------------------------------------------------------------
// hppd_back
// Palette RAM, hold-and-modify update and output register.
// ----------------------------------------------------------------------------
module hppd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  hppd_pkg::op_t       head_op,
  output logic                pop,
  output logic                rgb_valid,
  input  logic                rgb_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output hppd_pkg::bk_stat_t  stat
);

  hppd_pkg::rgb_t palette [hppd_pkg::PAL_ENTRIES];

  logic           en;
  logic           wr_ok;
  logic           rd_ok;
  hppd_pkg::rgb_t rd_data;
  hppd_pkg::rgb_t pal_color;
  hppd_pkg::rgb_t entry0;
  hppd_pkg::rgb_t held;
  hppd_pkg::rgb_t base;
  hppd_pkg::rgb_t ham_color;
  hppd_pkg::rgb_t result;
  logic           b_valid;
  hppd_pkg::op_t  b_op;
  logic           b_rd_ok;

  assign en    = !rgb_valid || !rgb_stall;
  assign pop   = en && head_valid;
  assign wr_ok = ({1'b0, head_op.addr} < 9'(hppd_pkg::PAL_ENTRIES));
  assign rd_ok = wr_ok;

  assign stat.pop     = pop;
  assign stat.b_valid = b_valid;

  // palette: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pop && head_op.cmd == hppd_pkg::CMD_PAL_WRITE && wr_ok) begin
      palette[head_op.addr[hppd_pkg::PAL_AW-1:0]] <= head_op.wdata;
    end
    if (en) begin
      rd_data <= palette[head_op.addr[hppd_pkg::PAL_AW-1:0]];
    end
  end

  // copy of entry 0 for line-start reload
  always_ff @(posedge clk) begin
    if (pop && head_op.cmd == hppd_pkg::CMD_PAL_WRITE && head_op.addr == 8'd0) begin
      entry0 <= head_op.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op    <= head_op;
      b_rd_ok <= rd_ok;
    end
  end

  always_comb begin
    pal_color = b_rd_ok ? rd_data : '0;
    base      = b_op.line_start ? entry0 : held;
    ham_color = base;
    case (b_op.ctrl)
      hppd_pkg::CTRL_LOAD:  ham_color   = pal_color;
      hppd_pkg::CTRL_BLUE:  ham_color.b = b_op.mod;
      hppd_pkg::CTRL_RED:   ham_color.r = b_op.mod;
      hppd_pkg::CTRL_GREEN: ham_color.g = b_op.mod;
      default:              ham_color   = base;
    endcase
    result = b_op.ham ? ham_color : pal_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      rgb_valid <= 1'b0;
      held      <= '0;
    end else if (en) begin
      b_valid   <= pop && head_op.cmd == hppd_pkg::CMD_PIXEL;
      rgb_valid <= b_valid;
      if (b_valid && b_op.ham) begin
        held <= ham_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && b_valid) begin
      red   <= result.r;
      green <= result.g;
      blue  <= result.b;
    end
  end

endmodule

// File: sv/ham_planar_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// ham_planar_pixel_decoder_unit
// Indexed / hold-and-modify pixel decoder to 24-bit RGB.
//
//   channel  handshake            payload
//   pix      pix_valid/pix_stall  command, entry_index, entry_*, pixel_bits
//   rgb      rgb_valid/rgb_stall  red, green, blue
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while rgb_stall is low; the palette RAM read
// and hold update form one back stage each. A pixel goes through the queue,
// the read stage and output register. Palette writes give no beat on rgb.
// Sync reset clears control state and held colour; palette RAM is not cleared.
// pix_stall rises only when the 4-entry op queue is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ham_planar_pixel_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic        command,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_red,
  input  logic [7:0]  entry_green,
  input  logic [7:0]  entry_blue,
  input  logic [7:0]  pixel_bits,
  output logic        rgb_valid,
  input  logic        rgb_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  hppd_pkg::cfg_t     cfg;
  hppd_pkg::op_t      push_op;
  hppd_pkg::op_t      head_op;
  hppd_pkg::q_stat_t  q_stat;
  hppd_pkg::bk_stat_t bk_stat;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ham_mode    <= 1'b1;
      cfg.plane_count <= 4'd6;
      cfg.line_width  <= 10'd88;
    end else if (cfg_valid && cfg_ready) begin
      case (hppd_pkg::cfg_reg_e'(cfg_index))
        hppd_pkg::REG_HAM_MODE:    cfg.ham_mode    <= cfg_data[0];
        hppd_pkg::REG_PLANE_COUNT: cfg.plane_count <= cfg_data[3:0];
        hppd_pkg::REG_LINE_WIDTH:  cfg.line_width  <= cfg_data;
        default:                   cfg             <= cfg;
      endcase
    end
  end

  hppd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .command     (command),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .pixel_bits  (pixel_bits),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (push_op)
  );

  hppd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .stat       (q_stat)
  );

  hppd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .stat       (bk_stat)
  );

  `HPPD_ASSERT_IMP(a_no_overflow, clk, rst, q_stat.push, q_stat.count != 3'(hppd_pkg::QUEUE_DEPTH))
  `HPPD_ASSERT_IMP(a_no_underflow, clk, rst, bk_stat.pop, q_stat.count != 3'd0)
  `HPPD_ASSERT_IMP(a_rgb_from_pixel, clk, rst, $rose(rgb_valid), $past(bk_stat.b_valid))
  `HPPD_ASSERT_NXT(a_stall_holds_b, clk, rst, rgb_valid && rgb_stall && bk_stat.b_valid, bk_stat.b_valid)

endmodule
